### design/url_percent_decoder_assert.svh
// Assertion macros for the URL percent decoder.
// Included by files that check their own logic; no other dependencies.
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check on clk_i, disabled while rst_ni is low.
`define UPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// A condition that must never be true.
`define UPD_NEVER(lbl, cond, msg) \
  `UPD_ASSERT(lbl, !(cond), msg)
`else
`define UPD_ASSERT(lbl, prop, msg)
`define UPD_NEVER(lbl, cond, msg)
`endif

`endif

### design/upd_pkg.sv
// Shared types and character codes for the URL percent decoder.
// No dependencies; used by upd_step and url_percent_decoder.
package upd_pkg;

  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperZ  = 8'h5A;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerZ  = 8'h7A;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] LetterBase = 8'd10;

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhPercent = 2'd1,
    PhHigh    = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
    phase_e     phase;
    logic [5:0] high;
  } step_t;

endpackage

### design/url_percent_decoder.sv
// Top level of the URL percent decoder: state registers and a two-entry result buffer.
// Depends on upd_pkg, upd_step and url_percent_decoder_assert.svh.
//
//   channel  | direction | tdata          | tlast
//   s_axis   | in        | [7:0] in_byte  | in_last
//   m_axis   | out       | [7:0] out_byte | out_last
//
// One request is taken per cycle while ready; a request that completes a character
// puts its result on m_axis the next cycle. A percent flushed at the end of a text
// gives two results, so the input stalls while the result buffer holds both of them.
// Input readiness follows the result buffer: it is ready when the buffer is
// empty, or holds one result that is taken in the same cycle.
// Reset returns to the idle phase and empties the buffer.
`include "url_percent_decoder_assert.svh"

module url_percent_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o
);

  upd_pkg::phase_e phase_q, phase_d;
  logic [5:0]      high_q, high_d;
  logic [1:0]      cnt_q, cnt_d;
  upd_pkg::res_t   res0_q, res0_d, res1_q, res1_d;
  upd_pkg::step_t  step;
  logic            accept, pop;

  upd_step u_step (
    .phase_i (phase_q),
    .high_i  (high_q),
    .byte_i  (s_axis_tdata_i),
    .last_i  (s_axis_tlast_i),
    .step_o  (step)
  );

  assign s_axis_tready_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = (cnt_q != 2'd0) && m_axis_tready_i;

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = res0_q.data;
  assign m_axis_tlast_o  = res0_q.last;

  always_comb begin
    phase_d = phase_q;
    high_d  = high_q;
    cnt_d   = cnt_q;
    res0_d  = res0_q;
    res1_d  = res1_q;
    if (accept) begin
      // An accepted request always finds the buffer empty after this cycle's pop.
      phase_d = step.phase;
      high_d  = step.high;
      cnt_d   = step.count;
      res0_d  = step.res0;
      res1_d  = step.res1;
    end else if (pop) begin
      cnt_d  = cnt_q - 2'd1;
      res0_d = res1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= upd_pkg::PhIdle;
      high_q  <= 6'd0;
      cnt_q   <= 2'd0;
    end else begin
      phase_q <= phase_d;
      high_q  <= high_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res0_q <= res0_d;
    res1_q <= res1_d;
  end

  `UPD_NEVER(a_no_accept_when_full, cnt_q == 2'd2 && s_axis_tready_o, "accepted with full buffer")
  `UPD_ASSERT(a_last_returns_idle, accept && s_axis_tlast_i |=> phase_q == upd_pkg::PhIdle, "phase not idle after last")
  `UPD_ASSERT(a_flush_fills_two, accept && step.count == 2'd2 |=> cnt_q == 2'd2 && !res0_q.last && res1_q.last, "flush not buffered as two results")
  `UPD_ASSERT(a_pending_holds, cnt_q == 2'd2 && !m_axis_tready_i |=> cnt_q == 2'd2 && $stable(res1_q), "pending result lost")

endmodule

### design/upd_step.sv
// Combinational decode of one input byte against the held percent state.
// Depends on upd_pkg for types and character codes.
module upd_step (
  input  upd_pkg::phase_e phase_i,
  input  logic [5:0]      high_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  output upd_pkg::step_t  step_o
);

  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c inside {[upd_pkg::ChUpperA:upd_pkg::ChUpperZ]}) begin
        t = c - upd_pkg::ChUpperA + upd_pkg::LetterBase;
      end else if (c inside {[upd_pkg::ChLowerA:upd_pkg::ChLowerZ]}) begin
        t = c - upd_pkg::ChLowerA + upd_pkg::LetterBase;
      end else if (c inside {[upd_pkg::ChZero:upd_pkg::ChNine]}) begin
        t = c - upd_pkg::ChZero;
      end
      digit_value = t[5:0];
    end
  endfunction

  logic [7:0] plain;
  logic [5:0] digit;

  assign plain = (byte_i == upd_pkg::ChPlus) ? upd_pkg::ChSpace : byte_i;
  assign digit = digit_value(byte_i);

  always_comb begin
    step_o       = '0;
    step_o.phase = upd_pkg::PhIdle;
    step_o.high  = high_i;
    case (phase_i)
      upd_pkg::PhPercent: begin
        if (last_i) begin
          // Text ended one byte after the percent: flush it literally.
          step_o.count = 2'd2;
          step_o.res0  = '{data: upd_pkg::ChPercent, last: 1'b0};
          step_o.res1  = '{data: plain, last: 1'b1};
        end else begin
          step_o.high  = digit;
          step_o.phase = upd_pkg::PhHigh;
        end
      end
      upd_pkg::PhHigh: begin
        step_o.count = 2'd1;
        step_o.res0  = '{data: {high_i[3:0], 4'b0000} | {2'b00, digit}, last: last_i};
      end
      default: begin
        if (byte_i == upd_pkg::ChPercent && !last_i) begin
          step_o.phase = upd_pkg::PhPercent;
        end else begin
          step_o.count = 2'd1;
          step_o.res0  = '{data: plain, last: last_i};
        end
      end
    endcase
  end

endmodule
